FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(label, prop, msg)

`define ASSERT_CLK(label, prop, msg)

`endif

`endif

FILE: rtl/vil_pkg.sv
package vil_pkg;

    localparam int NumChannels = 4;

    // Configuration register indexes.
    localparam logic [1:0] CfgGain      = 2'd0;
    localparam logic [1:0] CfgTolerance = 2'd1;
    localparam logic [1:0] CfgLockTime  = 2'd2;

    localparam logic [9:0]  GainReset      = 10'd192;
    localparam logic [7:0]  ToleranceReset = 8'd13;
    localparam logic [7:0]  LockTimeReset  = 8'd10;
    localparam logic [11:0] DriveIdle      = 12'd4095;

    localparam int DriveW = 12;
    localparam int CountW = 8;
    // Channel memory word: drive, lock counter, lock flag.
    localparam int MemW   = DriveW + CountW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

endpackage

FILE: rtl/voltage_integral_loop_with_lock_core.sv
// Integral voltage regulator with lock detection for a set of supply channels.
// Input channel: i_in_valid / o_in_stall with the fields i_channel,
// i_loop_enable, i_measured_voltage and i_setpoint. Each request gives one
// result on o_out_valid / i_out_stall carrying o_out_channel, o_drive_value
// and o_locked. Configuration is a plain write port (i_cfg_we, i_cfg_index,
// i_cfg_data): index 0 gain, 1 lock tolerance, 2 lock time.
// A request is taken only in the idle state; no new request is taken until the
// read, multiply, update and write-back sequence on the channel memory is done.
// The result is loaded into the output register at write-back.
// The per-channel drive, lock counter and lock flag live in one memory with
// a registered read. Per-channel valid bits make a channel that was never
// written read as drive 4095, counter 0 and flag clear.
// Reset is synchronous and active low; it restores the register defaults,
// clears the valid bits and empties the output register. There is no clearing
// pass, so requests are taken from the first cycle after reset.
// A stalled result is held in the output register while the next request is
// taken and processed; that request waits for write-back until the output
// register frees up.
`include "assert_macros.svh"

module voltage_integral_loop_with_lock_core #(
    parameter int NUM_CHANNELS = vil_pkg::NumChannels
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_channel,
    input  logic               i_loop_enable,
    input  logic signed [12:0] i_measured_voltage,
    input  logic [9:0]         i_setpoint,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_out_channel,
    output logic [11:0]        o_drive_value,
    output logic               o_locked,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);

    import vil_pkg::*;

    localparam int AddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [4:0] ChLimit = 5'(NUM_CHANNELS);

    t_state r_state, n_state;

    logic [9:0] r_gain;
    logic [7:0] r_tol;
    logic [7:0] r_ltime;

    logic [NUM_CHANNELS-1:0] r_valid;

    logic [AddrW-1:0]   r_addr;
    logic [1:0]         r_ch;
    logic               r_ch_ok;
    logic               r_en;
    logic signed [12:0] r_meas;
    logic [9:0]         r_sp;

    logic signed [13:0] r_err;
    logic [11:0]        r_drive;
    logic [7:0]         r_cnt;
    logic               r_flag;

    logic signed [24:0] r_prod;
    logic [18:0]        r_thr;
    logic [12:0]        r_mag;

    logic [11:0] r_new_drive;
    logic [7:0]  r_new_cnt;
    logic        r_new_flag;

    logic        r_out_valid;
    logic [1:0]  r_out_ch;
    logic [11:0] r_out_drive;
    logic        r_out_locked;

    logic             in_accept;
    logic             out_free;
    logic             ram_we;
    logic             out_load;
    logic [AddrW-1:0] ram_raddr;
    logic [MemW-1:0]  ram_rdata;
    logic [MemW-1:0]  ram_wdata;

    logic               rd_hit;
    logic [11:0]        rd_drive;
    logic [7:0]         rd_cnt;
    logic               rd_flag;
    logic signed [13:0] err_c;
    logic [12:0]        mag_c;
    logic signed [17:0] sum_c;
    logic [11:0]        clamp_c;
    logic               out_tol_c;
    logic [11:0]        upd_drive;
    logic [7:0]         upd_cnt;
    logic               upd_flag;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign ram_raddr = AddrW'(i_channel);
    assign ram_wdata = {r_new_drive, r_new_cnt, r_new_flag};

    vil_ram #(
        .WIDTH(MemW),
        .DEPTH(NUM_CHANNELS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GainReset;
            r_tol   <= ToleranceReset;
            r_ltime <= LockTimeReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgGain:      r_gain  <= i_cfg_data;
                CfgTolerance: r_tol   <= i_cfg_data[7:0];
                CfgLockTime:  r_ltime <= i_cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_MUL;
            S_MUL:  n_state = S_UPD;
            S_UPD:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ram_we   = r_ch_ok;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A channel that was never written reads as its reset contents.
    assign rd_hit   = r_ch_ok && r_valid[r_addr];
    assign rd_drive = rd_hit ? ram_rdata[MemW-1 -: DriveW] : DriveIdle;
    assign rd_cnt   = rd_hit ? ram_rdata[CountW:1] : '0;
    assign rd_flag  = rd_hit ? ram_rdata[0] : 1'b0;
    assign err_c    = $signed({r_meas[12], r_meas}) - $signed({4'b0, r_sp});
    assign mag_c    = r_err[13] ? 13'(-r_err) : r_err[12:0];

    // Floor of product / 256 is the arithmetic shift of the product.
    assign sum_c = $signed({6'b0, r_drive}) + 18'($signed(r_prod[24:8]));

    always_comb begin
        if (sum_c < 0) begin
            clamp_c = '0;
        end else if (sum_c > $signed({6'b0, DriveIdle})) begin
            clamp_c = DriveIdle;
        end else begin
            clamp_c = sum_c[11:0];
        end
    end

    // floor(mag * 256 / sp) > tol holds exactly when mag * 256 >= (tol + 1) * sp;
    // a zero setpoint lands on the out-of-tolerance side as required.
    assign out_tol_c = {r_mag, 8'b0} >= {2'b0, r_thr};

    always_comb begin
        upd_drive = DriveIdle;
        upd_cnt   = r_cnt;
        upd_flag  = 1'b0;
        if (!r_ch_ok) begin
            upd_drive = DriveIdle;
            upd_flag  = 1'b0;
        end else if (!r_en) begin
            upd_drive = DriveIdle;
            upd_flag  = r_flag;
        end else begin
            upd_drive = clamp_c;
            if (out_tol_c) begin
                upd_cnt  = '0;
                upd_flag = 1'b0;
            end else if (r_cnt < r_ltime) begin
                upd_cnt  = r_cnt + 8'd1;
                upd_flag = 1'b0;
            end else begin
                upd_flag = 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr  <= ram_raddr;
            r_ch    <= i_channel;
            r_ch_ok <= {3'b0, i_channel} < ChLimit;
            r_en    <= i_loop_enable;
            r_meas  <= i_measured_voltage;
            r_sp    <= i_setpoint;
        end
        if (r_state == S_READ) begin
            r_err   <= err_c;
            r_drive <= rd_drive;
            r_cnt   <= rd_cnt;
            r_flag  <= rd_flag;
        end
        if (r_state == S_MUL) begin
            r_prod <= 25'(r_err) * 25'($signed({1'b0, r_gain}));
            r_thr  <= 19'({1'b0, r_tol} + 9'd1) * 19'(r_sp);
            r_mag  <= mag_c;
        end
        if (r_state == S_UPD) begin
            r_new_drive <= upd_drive;
            r_new_cnt   <= upd_cnt;
            r_new_flag  <= upd_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch     <= r_ch;
            r_out_drive  <= r_new_drive;
            r_out_locked <= r_new_flag;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_drive_value = r_out_drive;
    assign o_locked      = r_out_locked;

    `ASSERT_CLK_RST(a_write_only_at_done,
        ram_we |-> (r_state == S_DONE && r_ch_ok),
        "memory write outside write-back")
    `ASSERT_CLK_RST(a_accept_starts_read,
        in_accept |=> (r_state == S_READ),
        "accepted request did not start a read")
    `ASSERT_CLK_RST(a_bad_channel_idle,
        (o_out_valid && ({3'b0, o_out_channel} >= ChLimit))
            |-> (!o_locked && o_drive_value == DriveIdle),
        "unknown channel gave a non-idle result")

endmodule

FILE: rtl/vil_ram.sv
module vil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/vil_drive_checker.sv
`timescale 1ns / 1ps

module vil_drive_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_channel,
    input  logic               i_loop_enable,
    input  logic signed [12:0] i_measured_voltage,
    input  logic [9:0]         i_setpoint,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_out_channel,
    input  logic [11:0]        i_drive_value,
    input  logic               i_locked,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    output int                 o_pending,
    output int                 o_errors
);

    import vil_pkg::*;

    typedef struct packed {
        logic [1:0]  chan;
        logic [11:0] drive;
        logic        locked;
    } t_drive_result;

    logic [9:0]  gain;
    logic [7:0]  tolerance;
    logic [7:0]  lock_time;
    logic [11:0] drive_mirror [NumChannels];
    logic [7:0]  count_mirror [NumChannels];
    logic        flag_mirror  [NumChannels];

    t_drive_result results_due [$];
    int            error_count = 0;

    // Advances the mirrored channel state by one request and returns its result.
    function automatic t_drive_result regulate_step(input logic [1:0] ch, input logic en,
                                                    input logic signed [12:0] meas,
                                                    input logic [9:0] sp);
        int            err;
        int            ctl;
        int            mag;
        int            rel_err;
        logic          in_tol;
        t_drive_result res;
        res.chan = ch;
        if (int'(ch) >= NumChannels) begin
            res.drive  = DriveIdle;
            res.locked = 1'b0;
            return res;
        end
        if (!en) begin
            drive_mirror[ch] = DriveIdle;
            res.drive  = DriveIdle;
            res.locked = flag_mirror[ch];
            return res;
        end
        err = int'(meas) - int'(sp);
        // Arithmetic shift of a signed product rounds toward minus infinity.
        ctl = int'(drive_mirror[ch]) + ((err * int'(gain)) >>> 8);
        if (ctl > int'(DriveIdle)) ctl = int'(DriveIdle);
        if (ctl < 0) ctl = 0;
        drive_mirror[ch] = ctl[11:0];
        mag = (err < 0) ? -err : err;
        // A zero setpoint is never in tolerance.
        if (sp == 10'd0) begin
            in_tol = 1'b0;
        end else begin
            rel_err = (mag * 256) / int'(sp);
            in_tol  = (rel_err <= int'(tolerance));
        end
        if (!in_tol) begin
            count_mirror[ch] = 8'd0;
            flag_mirror[ch]  = 1'b0;
        end else if (count_mirror[ch] < lock_time) begin
            count_mirror[ch] = count_mirror[ch] + 8'd1;
            flag_mirror[ch]  = 1'b0;
        end else begin
            flag_mirror[ch] = 1'b1;
        end
        res.drive  = drive_mirror[ch];
        res.locked = flag_mirror[ch];
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_drive_result got;
        t_drive_result want;
        if (!i_rst_n) begin
            gain      = GainReset;
            tolerance = ToleranceReset;
            lock_time = LockTimeReset;
            for (int i = 0; i < NumChannels; i++) begin
                drive_mirror[i] = DriveIdle;
                count_mirror[i] = 8'd0;
                flag_mirror[i]  = 1'b0;
            end
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgGain:      gain      = i_cfg_data;
                    CfgTolerance: tolerance = i_cfg_data[7:0];
                    CfgLockTime:  lock_time = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_out_channel, i_drive_value, i_locked};
                if (results_due.size() == 0) begin
                    $display("%0t: result with no request pending: expected none, actual %p",
                             $time, got);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.chan != want.chan) begin
                        $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                                 $time, want.chan, got.chan);
                        error_count++;
                    end
                    if (got.drive != want.drive) begin
                        $display("%0t: drive_value mismatch on ch %0d: expected %0d, actual %0d",
                                 $time, want.chan, want.drive, got.drive);
                        error_count++;
                    end
                    if (got.locked != want.locked) begin
                        $display("%0t: locked mismatch on ch %0d: expected %0d, actual %0d",
                                 $time, want.chan, want.locked, got.locked);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(regulate_step(i_channel, i_loop_enable,
                                                    i_measured_voltage, i_setpoint));
            end
        end
        o_pending <= results_due.size();
        o_errors  <= error_count;
    end

endmodule

FILE: tb/tb_voltage_integral_loop_with_lock_core.sv
`timescale 1ns / 1ps

module tb_voltage_integral_loop_with_lock_core;

    import vil_pkg::*;

    localparam logic [1:0] CfgUnused  = 2'd3;
    localparam int         CycleLimit = 600000;
    localparam int         PhaseItems = 200;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               in_valid           = 1'b0;
    logic [1:0]         channel            = 2'd0;
    logic               loop_enable        = 1'b0;
    logic signed [12:0] measured_voltage   = 13'sd0;
    logic [9:0]         setpoint           = 10'd0;
    logic               out_stall          = 1'b0;
    logic               cfg_we             = 1'b0;
    logic [1:0]         cfg_index          = 2'd0;
    logic [9:0]         cfg_data           = 10'd0;
    logic               in_stall;
    logic               out_valid;
    logic [1:0]         out_channel;
    logic [11:0]        drive_value;
    logic               locked;
    int                 pending;
    int                 errors;

    int tx_idle_pct = 19;
    int rx_idle_pct = 84;
    int cur_tol     = int'(ToleranceReset);
    int cycles      = 0;

    voltage_integral_loop_with_lock_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_channel          (channel),
        .i_loop_enable      (loop_enable),
        .i_measured_voltage (measured_voltage),
        .i_setpoint         (setpoint),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_channel      (out_channel),
        .o_drive_value      (drive_value),
        .o_locked           (locked),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    vil_drive_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_channel          (channel),
        .i_loop_enable      (loop_enable),
        .i_measured_voltage (measured_voltage),
        .i_setpoint         (setpoint),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_out_channel      (out_channel),
        .i_drive_value      (drive_value),
        .i_locked           (locked),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_pending          (pending),
        .o_errors           (errors)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("[voltage_integral_loop_with_lock_core] ERROR");
            $finish;
        end
    end

    // Presents one request, with an optional idle gap ahead of it, and waits until taken.
    task automatic send_request(input logic [1:0] ch, input logic en, input int meas,
                                input logic [9:0] sp);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid         <= 1'b1;
        channel          <= ch;
        loop_enable      <= en;
        measured_voltage <= meas[12:0];
        setpoint         <= sp;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [9:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CfgTolerance) cur_tol = int'(data[7:0]);
    endtask

    // Mostly samples close to the setpoint so that lock streaks build up.
    task automatic send_random_request(inout logic [1:0] last_ch);
        logic [1:0] ch;
        logic       en;
        logic [9:0] sp;
        int         meas;
        int         bound;
        int         pick;
        ch = ($urandom_range(99) < 40) ? last_ch : 2'($urandom_range(3));
        last_ch = ch;
        en = ($urandom_range(99) < 92);
        pick = $urandom_range(99);
        if (pick < 85) sp = 10'($urandom_range(250, 750));
        else if (pick < 95) sp = 10'($urandom_range(1023));
        else sp = 10'd0;
        pick = $urandom_range(99);
        if (pick < 65) begin
            bound = (int'(sp) * cur_tol) / 256 + 2;
            meas  = int'(sp) + $urandom_range(2 * bound) - bound;
            if (meas > 4095) meas = 4095;
        end else if (pick < 90) begin
            meas = $urandom_range(8191) - 4096;
        end else begin
            meas = ($urandom_range(1) != 0) ? 4095 : -4096;
        end
        send_request(ch, en, meas, sp);
    endtask

    initial begin : stimulus
        logic [1:0] last_ch;
        last_ch = 2'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Channel 0 drive saturates high; channel 1 falls hard and saturates at zero.
        send_request(2'd0, 1'b1, 4095, 10'd250);
        send_request(2'd0, 1'b1, 4095, 10'd250);
        send_request(2'd1, 1'b1, -4096, 10'd750);
        send_request(2'd1, 1'b1, -4096, 10'd750);
        // Ten in-tolerance steps bring the counter to the lock time, flag still low.
        for (int i = 0; i < 10; i++) send_request(2'd2, 1'b1, 499 + (i % 3), 10'd500);
        send_request(2'd2, 1'b0, 0, 10'd500);
        send_request(2'd3, 1'b1, 0, 10'd0);
        send_request(2'd3, 1'b1, -1, 10'd1023);
        send_request(2'd3, 1'b1, -4096, 10'd0);
        drain_results();
        // Lowering the lock time below the counter lets the next good step lock.
        write_cfg(CfgLockTime, 10'd3);
        write_cfg(CfgUnused, 10'h3FF);
        send_request(2'd2, 1'b1, 500, 10'd500);
        send_request(2'd2, 1'b0, -4096, 10'd250);
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_cfg(CfgGain, GainReset);
                    write_cfg(CfgTolerance, 10'(ToleranceReset));
                    write_cfg(CfgLockTime, 10'(LockTimeReset));
                end
                1: begin
                    write_cfg(CfgGain, 10'd1023);
                    write_cfg(CfgTolerance, 10'd255);
                    write_cfg(CfgLockTime, 10'd0);
                end
                2: begin
                    write_cfg(CfgGain, 10'd0);
                    write_cfg(CfgTolerance, 10'd0);
                    write_cfg(CfgLockTime, 10'd255);
                end
                default: begin
                    write_cfg(CfgGain, 10'($urandom_range(1023)));
                    write_cfg(CfgTolerance, {2'($urandom_range(3)), 8'($urandom_range(40))});
                    write_cfg(CfgLockTime, {2'($urandom_range(3)), 8'($urandom_range(12))});
                end
            endcase
            if (phase < 2) begin
                tx_idle_pct = 19;
                rx_idle_pct = 84;
            end else if (phase < 4) begin
                tx_idle_pct = 84;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PhaseItems; n++) begin
                if (n == PhaseItems / 2) drain_results();
                send_random_request(last_ch);
            end
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[voltage_integral_loop_with_lock_core] OK");
        end else begin
            $display("[voltage_integral_loop_with_lock_core] ERROR");
        end
        $finish;
    end

endmodule
